### src/nat_pkg.sv
// Shared types and constants for the NAT connection table.
// Used by nat_ctrl, nat_dp and nat_translation_table_lru_ttl.
`timescale 1ns / 1ps
package nat_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int MAXE_W  = 7;
   localparam int CMP_W   = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
   localparam int TS_W    = 48;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] OP_UPSERT  = 2'd0;
   localparam logic [1:0] OP_CONSUME = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TTL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX = 1'd1;

   localparam logic [31:0] TTL_RESET = 32'd60000;
   localparam logic [MAXE_W-1:0] MAX_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]      operation;
      logic [31:0]     dst_addr;
      logic [15:0]     dst_port;
      logic [31:0]     peer_addr;
      logic [15:0]     peer_port;
      logic [7:0]      protocol;
      logic [31:0]     orig_addr;
      logic [15:0]     orig_port;
      logic            conn_mode;
      logic [TS_W-1:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_ip;
      logic [15:0] found_port;
      logic        found_conn;
   } rsp_type;

   typedef struct packed {
      logic [31:0]     dst_addr;
      logic [15:0]     dst_port;
      logic [31:0]     peer_addr;
      logic [15:0]     peer_port;
      logic [7:0]      protocol;
      logic [31:0]     orig_addr;
      logic [15:0]     orig_port;
      logic            conn_flag;
      logic [TS_W-1:0] expiry;
      logic [TS_W-1:0] recency;
   } slot_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic scan_begin;
      logic ev_mode;
      logic scan;
      logic write;
      logic evict;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic       scan_done;
      logic       over_limit;
      logic       hit;
      logic [1:0] operation;
   } status_type;

endpackage

### src/nat_ctrl.sv
// Sequencer for the NAT table: scan, write, eviction loop, response.
// Depends on nat_pkg; drives nat_dp through cmd_type.
`timescale 1ns / 1ps
module nat_ctrl
   import nat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] start_op,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_EVCHK  = 3'd3;
   localparam logic [2:0] S_EVSCAN = 3'd4;
   localparam logic [2:0] S_EVICT  = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (start_op == OP_UPSERT || start_op == OP_CONSUME) begin
                  cmd.scan_begin = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.clear = (start_op == OP_CLEAR);
                  state_in  = S_RESP;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) state_in = S_WRITE;
         end
         S_WRITE: begin
            if (status.operation == OP_CONSUME) begin
               cmd.write = status.hit;
               state_in  = S_RESP;
            end else begin
               cmd.write = 1'b1;
               state_in  = S_EVCHK;
            end
         end
         S_EVCHK: begin
            if (status.over_limit) begin
               cmd.scan_begin = 1'b1;
               cmd.ev_mode    = 1'b1;
               state_in       = S_EVSCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_EVSCAN: begin
            cmd.scan    = 1'b1;
            cmd.ev_mode = 1'b1;
            if (status.scan_done) state_in = S_EVICT;
         end
         S_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = S_EVCHK;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### src/nat_dp.sv
// Datapath of the NAT table: slot memory, valid bits, scan trackers,
// config registers and the response register. Depends on nat_pkg.
`timescale 1ns / 1ps
module nat_dp
   import nat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output logic                 rsp_valid,
   output rsp_type              rsp
);

   slot_type mem [ENTRIES];
   slot_type rd_ff;

   req_type  req_ff;
   logic [31:0]       ttl_ff;
   logic [MAXE_W-1:0] max_ff;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               chk_valid_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic               ev_mode_ff;

   logic               match_ff, match_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [31:0]        m_ip_ff, m_ip_in;
   logic [15:0]        m_port_ff, m_port_in;
   logic               m_conn_ff, m_conn_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               old_ff, old_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [TS_W-1:0]    old_rec_ff, old_rec_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TS_W-1:0]    seq_ff, seq_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               scan_live, cur_valid, expired, key_eq;
   logic [IDX_W-1:0]   wr_idx;
   slot_type           wr_data;
   logic [TS_W:0]      exp_sum;
   logic [TS_W-1:0]    exp_sat;

   assign cur_valid = valid_ff[chk_idx_ff];
   assign expired   = (rd_ff.expiry <= req_ff.now_ticks);
   assign key_eq    = (rd_ff.dst_addr == req_ff.dst_addr) &&
                      (rd_ff.dst_port == req_ff.dst_port) &&
                      (rd_ff.peer_addr == req_ff.peer_addr) &&
                      (rd_ff.peer_port == req_ff.peer_port) &&
                      (rd_ff.protocol == req_ff.protocol);
   assign scan_live = cur_valid && (ev_mode_ff || !expired);

   assign exp_sum = {1'b0, req_ff.now_ticks} + {{(TS_W + 1 - 32){1'b0}}, ttl_ff};
   assign exp_sat = exp_sum[TS_W] ? {TS_W{1'b1}} : exp_sum[TS_W-1:0];

   // pick the slot for the write: key hit, then first free, then oldest
   always_comb begin
      priority if (match_ff) wr_idx = match_idx_ff;
      else if (free_ff)      wr_idx = free_idx_ff;
      else if (old_ff)       wr_idx = old_idx_ff;
      else                   wr_idx = '0;
   end

   always_comb begin
      wr_data.dst_addr  = req_ff.dst_addr;
      wr_data.dst_port  = req_ff.dst_port;
      wr_data.peer_addr = req_ff.peer_addr;
      wr_data.peer_port = req_ff.peer_port;
      wr_data.protocol  = req_ff.protocol;
      wr_data.expiry    = exp_sat;
      wr_data.recency   = seq_ff;
      if (req_ff.operation == OP_CONSUME) begin
         wr_data.orig_addr = m_ip_ff;
         wr_data.orig_port = m_port_ff;
         wr_data.conn_flag = m_conn_ff;
      end else begin
         wr_data.orig_addr = req_ff.orig_addr;
         wr_data.orig_port = req_ff.orig_port;
         wr_data.conn_flag = req_ff.conn_mode;
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      m_ip_in      = m_ip_ff;
      m_port_in    = m_port_ff;
      m_conn_in    = m_conn_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      old_rec_in   = old_rec_ff;
      cnt_in       = cnt_ff;
      seq_in       = seq_ff;

      if (cmd.clear) begin
         valid_in = '0;
         seq_in   = '0;
      end
      if (cmd.scan_begin) begin
         idx_in = '0;
         old_in = 1'b0;
         if (!cmd.ev_mode) begin
            match_in = 1'b0;
            free_in  = 1'b0;
            cnt_in   = '0;
         end
      end
      if (cmd.scan && idx_ff != CNT_W'(ENTRIES)) idx_in = idx_ff + 1'b1;

      if (chk_valid_ff) begin
         // purge expired entries on the main pass only
         if (!ev_mode_ff && cur_valid && expired) valid_in[chk_idx_ff] = 1'b0;
         if (!ev_mode_ff && !scan_live && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
         if (scan_live) begin
            if (!ev_mode_ff) begin
               cnt_in = cnt_ff + 1'b1;
               if (key_eq && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = chk_idx_ff;
                  m_ip_in      = rd_ff.orig_addr;
                  m_port_in    = rd_ff.orig_port;
                  m_conn_in    = rd_ff.conn_flag;
               end
            end
            if (!old_ff || rd_ff.recency < old_rec_ff) begin
               old_in     = 1'b1;
               old_idx_in = chk_idx_ff;
               old_rec_in = rd_ff.recency;
            end
         end
      end

      if (cmd.write) begin
         valid_in[wr_idx] = 1'b1;
         seq_in           = seq_ff + 1'b1;
         if (!match_ff && free_ff) cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.evict) begin
         if (old_ff) begin
            valid_in[old_idx_ff] = 1'b0;
            cnt_in               = cnt_ff - 1'b1;
         end else begin
            cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) mem[wr_idx] <= wr_data;
      rd_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         idx_ff       <= CNT_W'(ENTRIES);
         chk_valid_ff <= 1'b0;
         ev_mode_ff   <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         old_ff       <= 1'b0;
         cnt_ff       <= '0;
         seq_ff       <= '0;
         ttl_ff       <= TTL_RESET;
         max_ff       <= MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         idx_ff       <= idx_in;
         chk_valid_ff <= cmd.scan && (idx_ff != CNT_W'(ENTRIES));
         if (cmd.scan_begin) ev_mode_ff <= cmd.ev_mode;
         match_ff     <= match_in;
         free_ff      <= free_in;
         old_ff       <= old_in;
         cnt_ff       <= cnt_in;
         seq_ff       <= seq_in;
         if (csr_valid && csr_index == CSR_TTL) ttl_ff <= csr_data;
         if (csr_valid && csr_index == CSR_MAX) max_ff <= csr_data[MAXE_W-1:0];
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      chk_idx_ff   <= idx_ff[IDX_W-1:0];
      match_idx_ff <= match_idx_in;
      m_ip_ff      <= m_ip_in;
      m_port_ff    <= m_port_in;
      m_conn_ff    <= m_conn_in;
      free_idx_ff  <= free_idx_in;
      old_idx_ff   <= old_idx_in;
      old_rec_ff   <= old_rec_in;
      if (cmd.respond) begin
         if (req_ff.operation == OP_CONSUME && match_ff) begin
            rsp_ff.hit        <= 1'b1;
            rsp_ff.found_ip   <= m_ip_ff;
            rsp_ff.found_port <= m_port_ff;
            rsp_ff.found_conn <= m_conn_ff;
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   assign status.scan_done  = chk_valid_ff && (chk_idx_ff == IDX_W'(ENTRIES - 1));
   assign status.over_limit = (CMP_W'(cnt_ff) > CMP_W'(max_ff));
   assign status.hit        = match_ff;
   assign status.operation  = req_ff.operation;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### src/nat_translation_table_lru_ttl.sv
// A consume or upsert scans all 64 slots through one memory read port; each LRU
// eviction adds another full scan. Clear and unused operations skip the scan.
// One transaction at a time; busy stays high until the result strobe issues and
// the next start is accepted in the strobe cycle.
// Synchronous reset empties the table, zeroes the use counter and loads the
// default TTL and limit; no clearing pass. The receiver cannot stall rsp.
`timescale 1ns / 1ps
module nat_translation_table_lru_ttl
   import nat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req,
   output logic                 rsp_valid,
   output rsp_type              rsp,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   nat_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .start_op (req.operation),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   nat_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("transaction ended without result");

   a_hit_consume: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.hit) |-> $past(status.operation) == OP_CONSUME)
      else $error("hit reported for non-consume transaction");

endmodule
